[src/rucet_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rucet_pkg: shared types and constants of the unit cube entry test
// Payload structs of both channels, face codes and axis field selection.
// ----------------------------------------------------------------------------
package rucet_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int AXES          = 3;
  localparam int DATA_W        = 32;
  localparam int MARGIN_W      = 16;

  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = 16'd328;

  // Face codes: twice the axis, plus one for the face at 1.
  localparam logic [2:0] FACE_NONE = 3'd0;
  localparam logic [2:0] FACE_MAX  = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic              hit;
    logic [2:0]        face;
    logic [DATA_W-1:0] ray_param;
  } ray_out_t;

  function automatic logic signed [DATA_W-1:0] axis_origin(ray_in_t r, int unsigned a);
    logic signed [DATA_W-1:0] v;
    unique case (a)
      0: v = r.origin_x;
      1: v = r.origin_y;
      default: v = r.origin_z;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] axis_dir(ray_in_t r, int unsigned a);
    logic signed [DATA_W-1:0] v;
    unique case (a)
      0: v = r.dir_x;
      1: v = r.dir_y;
      default: v = r.dir_z;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/rucet_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rucet_prep: per-axis setup
// Picks the entry plane of each axis, forms the distance to it and the
// direction magnitude, and flags the axes that can offer a candidate.
// ----------------------------------------------------------------------------
module rucet_prep
  import rucet_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire ray_in_t           ray_in,
  output logic                   valid,
  output ray_in_t                ray,
  output logic [AXES-1:0]        cand,
  output logic [DATA_W-1:0]      num [AXES],
  output logic [DATA_W-1:0]      mag [AXES]
);

  localparam logic signed [DATA_W:0] PLANE_ONE = (DATA_W+1)'(1) <<< FRAC_BITS;

  logic [AXES-1:0]   cand_next;
  logic [DATA_W-1:0] num_next [AXES];
  logic [DATA_W-1:0] mag_next [AXES];

  always_comb begin
    logic signed [DATA_W-1:0] o;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W:0]   delta;
    for (int i = 0; i < AXES; i++) begin
      o = axis_origin(ray_in, i);
      d = axis_dir(ray_in, i);
      // A positive direction enters through the face at 0, a negative one at 1.
      if (d[DATA_W-1]) begin
        delta = {o[DATA_W-1], o} - PLANE_ONE;
      end else begin
        delta = '0 - {o[DATA_W-1], o};
      end
      cand_next[i] = (d != '0) && !delta[DATA_W] && (delta != '0);
      num_next[i]  = delta[DATA_W-1:0];
      mag_next[i]  = d[DATA_W-1] ? DATA_W'(-d) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray  <= ray_in;
      cand <= cand_next;
      num  <= num_next;
      mag  <= mag_next;
    end
  end

endmodule
`default_nettype wire

[src/rucet_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rucet_div: pipelined restoring divider, three lanes
// One quotient bit per stage gives t = (num << FRAC_BITS) / mag on each axis.
// ----------------------------------------------------------------------------
module rucet_div
  import rucet_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        valid_in,
  input  wire ray_in_t                     ray_in,
  input  wire logic [AXES-1:0]             cand_in,
  input  wire logic [DATA_W-1:0]           num_in [AXES],
  input  wire logic [DATA_W-1:0]           mag_in [AXES],
  output logic                             valid,
  output ray_in_t                          ray,
  output logic [AXES-1:0]                  cand,
  output logic [DATA_W+FRAC_BITS-1:0]      quo [AXES],
  output logic [DATA_W-1:0]                mag [AXES]
);

  localparam int QW = DATA_W + FRAC_BITS;

  logic              vld_s  [QW];
  ray_in_t           ray_s  [QW];
  logic [AXES-1:0]   cand_s [QW];
  logic [DATA_W-1:0] rem_s  [QW][AXES];
  logic [QW-1:0]     quo_s  [QW][AXES];
  logic [QW-1:0]     dvd_s  [QW][AXES];
  logic [DATA_W-1:0] mag_s  [QW][AXES];

  logic [DATA_W-1:0] rem_prev [QW][AXES];
  logic [QW-1:0]     quo_prev [QW][AXES];
  logic [QW-1:0]     dvd_prev [QW][AXES];
  logic [DATA_W-1:0] mag_prev [QW][AXES];

  logic [DATA_W-1:0] rem_next [QW][AXES];
  logic [QW-1:0]     quo_next [QW][AXES];
  logic [QW-1:0]     dvd_next [QW][AXES];

  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      rem_prev[0][l] = '0;
      quo_prev[0][l] = '0;
      dvd_prev[0][l] = {num_in[l], {FRAC_BITS{1'b0}}};
      mag_prev[0][l] = mag_in[l];
    end
    for (int s = 1; s < QW; s++) begin
      rem_prev[s] = rem_s[s-1];
      quo_prev[s] = quo_s[s-1];
      dvd_prev[s] = dvd_s[s-1];
      mag_prev[s] = mag_s[s-1];
    end
  end

  always_comb begin
    logic [DATA_W:0] trial;
    logic            ge;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < AXES; l++) begin
        trial = {rem_prev[s][l], dvd_prev[s][l][QW-1]};
        ge    = trial >= {1'b0, mag_prev[s][l]};
        rem_next[s][l] = ge ? DATA_W'(trial - {1'b0, mag_prev[s][l]})
                            : trial[DATA_W-1:0];
        quo_next[s][l] = {quo_prev[s][l][QW-2:0], ge};
        dvd_next[s][l] = {dvd_prev[s][l][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        vld_s[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_s[0] <= valid_in;
      for (int s = 1; s < QW; s++) begin
        vld_s[s] <= vld_s[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_s[0]  <= ray_in;
      cand_s[0] <= cand_in;
      for (int s = 1; s < QW; s++) begin
        ray_s[s]  <= ray_s[s-1];
        cand_s[s] <= cand_s[s-1];
      end
      rem_s <= rem_next;
      quo_s <= quo_next;
      dvd_s <= dvd_next;
      mag_s <= mag_prev;
    end
  end

  assign valid = vld_s[QW-1];
  assign ray   = ray_s[QW-1];
  assign cand  = cand_s[QW-1];
  assign quo   = quo_s[QW-1];
  assign mag   = mag_s[QW-1];

endmodule
`default_nettype wire

[src/rucet_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rucet_check: hit point range check
// For each candidate axis, projects the hit point onto the two other axes
// over four stages (split multiply, sum, offset, range compare).
// ----------------------------------------------------------------------------
module rucet_check
  import rucet_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [MARGIN_W-1:0]         margin,
  input  wire logic                        valid_in,
  input  wire ray_in_t                     ray_in,
  input  wire logic [AXES-1:0]             cand_in,
  input  wire logic [DATA_W+FRAC_BITS-1:0] t_in [AXES],
  input  wire logic [DATA_W-1:0]           mag_in [AXES],
  output logic                             valid,
  output logic [AXES-1:0]                  ok,
  output logic [DATA_W+FRAC_BITS-1:0]      t [AXES],
  output logic [AXES-1:0]                  neg
);

  localparam int QW = DATA_W + FRAC_BITS;
  localparam int PW = QW + DATA_W;
  localparam int HW = FRAC_BITS + DATA_W;

  // Stage 1: partial products of t by the other two direction magnitudes.
  logic                     v1;
  logic [AXES-1:0]          cand1;
  logic [AXES-1:0]          neg1;
  logic [QW-1:0]            t1   [AXES];
  logic signed [DATA_W-1:0] org1 [AXES];
  logic [63:0]              pl1  [AXES][2];
  logic [HW-1:0]            ph1  [AXES][2];
  // Stage 2: full products.
  logic                     v2;
  logic [AXES-1:0]          cand2;
  logic [AXES-1:0]          neg2;
  logic [QW-1:0]            t2   [AXES];
  logic signed [DATA_W-1:0] org2 [AXES];
  logic [PW-1:0]            prod2 [AXES][2];
  // Stage 3: hit point coordinates.
  logic                     v3;
  logic [AXES-1:0]          cand3;
  logic [AXES-1:0]          neg3;
  logic [QW-1:0]            t3   [AXES];
  logic signed [63:0]       pt3  [AXES][2];
  logic                     over3 [AXES][2];

  logic [AXES-1:0]          cand1_next;
  logic [AXES-1:0]          neg1_next;
  logic signed [DATA_W-1:0] org1_next [AXES];
  logic [63:0]              pl1_next  [AXES][2];
  logic [HW-1:0]            ph1_next  [AXES][2];
  logic [PW-1:0]            prod2_next [AXES][2];
  logic signed [63:0]       pt3_next  [AXES][2];
  logic                     over3_next [AXES][2];
  logic [AXES-1:0]          ok_next;

  always_comb begin
    int k;
    logic [DATA_W-1:0] t_lo;
    logic [FRAC_BITS-1:0] t_hi;
    logic signed [DATA_W-1:0] dv;
    for (int i = 0; i < AXES; i++) begin
      cand1_next[i] = cand_in[i] && (t_in[i] != '0);
      dv            = axis_dir(ray_in, i);
      neg1_next[i]  = dv[DATA_W-1];
      org1_next[i]  = axis_origin(ray_in, i);
      t_lo = t_in[i][DATA_W-1:0];
      t_hi = t_in[i][QW-1:DATA_W];
      for (int j = 0; j < 2; j++) begin
        k = i + 1 + j;
        if (k >= AXES) begin
          k = k - AXES;
        end
        pl1_next[i][j] = t_lo * mag_in[k];
        ph1_next[i][j] = t_hi * mag_in[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < 2; j++) begin
        prod2_next[i][j] = {ph1[i][j], {DATA_W{1'b0}}} + PW'(pl1[i][j]);
      end
    end
  end

  always_comb begin
    int k;
    logic [63:0] term;
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < 2; j++) begin
        k = i + 1 + j;
        if (k >= AXES) begin
          k = k - AXES;
        end
        // Products beyond 2^62 put the point far outside the margin.
        over3_next[i][j] = (|prod2[i][j][PW-1:63]) ||
                           (prod2[i][j][62] && (|prod2[i][j][61:0]));
        term = 64'(prod2[i][j][62:FRAC_BITS]);
        pt3_next[i][j] = neg2[k] ? (64'(org2[k]) - term) : (64'(org2[k]) + term);
      end
    end
  end

  always_comb begin
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [1:0]         in_rng;
    lo = 64'sd0 - $signed({48'd0, margin});
    hi = (64'sd1 <<< FRAC_BITS) + $signed({48'd0, margin});
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < 2; j++) begin
        in_rng[j] = !over3[i][j] && (pt3[i][j] >= lo) && (pt3[i][j] <= hi);
      end
      // The plane itself always lies within range on the candidate's own axis.
      ok_next[i] = cand3[i] && in_rng[0] && in_rng[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1    <= valid_in;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cand1 <= cand1_next;
      neg1  <= neg1_next;
      t1    <= t_in;
      org1  <= org1_next;
      pl1   <= pl1_next;
      ph1   <= ph1_next;

      cand2 <= cand1;
      neg2  <= neg1;
      t2    <= t1;
      org2  <= org1;
      prod2 <= prod2_next;

      cand3 <= cand2;
      neg3  <= neg2;
      t3    <= t2;
      pt3   <= pt3_next;
      over3 <= over3_next;

      ok  <= ok_next;
      t   <= t3;
      neg <= neg3;
    end
  end

endmodule
`default_nettype wire

[src/ray_unit_cube_entry_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_unit_cube_entry_test: ray entry test against the unit cube
// Finds the entry face of an object-space ray into [0,1]^3 and its t.
// ----------------------------------------------------------------------------
// Usage:
//   A ray is taken on in_data when in_valid is high and in_stall is low; the
//   result appears on out_data with out_valid and is taken when out_stall is
//   low. One result leaves for every ray, in order.
//   Each ray passes one setup stage, one divider stage per quotient bit
//   (32 + FRAC_BITS), four stages of hit point checks and the select/output
//   register. Throughput is one ray per cycle unless out_stall freezes the
//   pipeline; the bit-serial divider pipeline does not limit the rate. When
//   the output register holds a result and out_stall is high, the whole
//   pipeline freezes and in_stall goes high; nothing is lost or repeated.
//   Reset clears all valid bits and sets edge_margin to 328 (0.005). The
//   user must see that edge_margin is written through cfg_wen/cfg_wdata
//   only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ray_unit_cube_entry_test
  import rucet_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ray_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ray_out_t                 out_data,
  input  wire logic                cfg_wen,
  input  wire logic [MARGIN_W-1:0] cfg_wdata
);

  localparam int QW = DATA_W + FRAC_BITS;

  logic [MARGIN_W-1:0] edge_margin;
  logic                adv;

  logic              prep_valid;
  ray_in_t           prep_ray;
  logic [AXES-1:0]   prep_cand;
  logic [DATA_W-1:0] prep_num [AXES];
  logic [DATA_W-1:0] prep_mag [AXES];

  logic              div_valid;
  ray_in_t           div_ray;
  logic [AXES-1:0]   div_cand;
  logic [QW-1:0]     div_quo [AXES];
  logic [DATA_W-1:0] div_mag [AXES];

  logic              chk_valid;
  logic [AXES-1:0]   chk_ok;
  logic [QW-1:0]     chk_t [AXES];
  logic [AXES-1:0]   chk_neg;

  ray_out_t          result_next;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_margin <= EDGE_MARGIN_RST;
    end else if (cfg_wen) begin
      edge_margin <= cfg_wdata;
    end
  end

  rucet_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .ray_in   (in_data),
    .valid    (prep_valid),
    .ray      (prep_ray),
    .cand     (prep_cand),
    .num      (prep_num),
    .mag      (prep_mag)
  );

  rucet_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (prep_valid),
    .ray_in   (prep_ray),
    .cand_in  (prep_cand),
    .num_in   (prep_num),
    .mag_in   (prep_mag),
    .valid    (div_valid),
    .ray      (div_ray),
    .cand     (div_cand),
    .quo      (div_quo),
    .mag      (div_mag)
  );

  rucet_check #(.FRAC_BITS(FRAC_BITS)) u_check (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .margin   (edge_margin),
    .valid_in (div_valid),
    .ray_in   (div_ray),
    .cand_in  (div_cand),
    .t_in     (div_quo),
    .mag_in   (div_mag),
    .valid    (chk_valid),
    .ok       (chk_ok),
    .t        (chk_t),
    .neg      (chk_neg)
  );

  // Axes are taken in order x, y, z; a tie keeps the earlier axis.
  always_comb begin
    logic          hit;
    logic [QW-1:0] best;
    logic [2:0]    face;
    hit  = 1'b0;
    best = '0;
    face = FACE_NONE;
    for (int i = 0; i < AXES; i++) begin
      if (chk_ok[i] && (!hit || (chk_t[i] < best))) begin
        hit  = 1'b1;
        best = chk_t[i];
        face = {2'(i), chk_neg[i]};
      end
    end
    result_next.hit       = hit;
    result_next.face      = face;
    result_next.ray_param = (|best[QW-1:DATA_W]) ? '1 : best[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTH
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.face == FACE_NONE && out_data.ray_param == '0)
    else $error("miss result carries a nonzero face or ray parameter");

  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.face <= FACE_MAX && out_data.ray_param != '0)
    else $error("hit result has a bad face code or a zero ray parameter");

  a_entry_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> prep_valid)
    else $error("accepted ray did not enter the setup stage");
`endif

endmodule
`default_nettype wire

[sim/ray_unit_cube_entry_test_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_unit_cube_entry_test_tb: self-checking bench of the unit cube entry test
// Streams directed and random rays through the block in bursts, stalls the
// result side on its own pattern, predicts hit, face and t for each ray and
// compares every result transfer in order. Several edge margins are used.
// ----------------------------------------------------------------------------
module ray_unit_cube_entry_test_tb;
  import rucet_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int LATENCY   = FB + 38;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 300;
  localparam longint ONE   = 64'sd1 <<< FB;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ray_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ray_out_t          out_data;
  logic              cfg_wen = 1'b0;
  logic [MARGIN_W-1:0] cfg_wdata = '0;

  ray_in_t  pending_rays[$];
  ray_out_t expected_hits[$];
  logic [MARGIN_W-1:0] margin = EDGE_MARGIN_RST;
  int errors = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int idle_cycles = 0;
  bit drive_on = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  always #6 clk = ~clk;

  ray_unit_cube_entry_test DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic bit point_in_margin(int ax, longint plane, longint o[3],
                                         longint d[3], longint unsigned t);
    longint lo, hi, p;
    longint unsigned m, term;
    lo = -longint'(margin);
    hi = ONE + longint'(margin);
    for (int k = 0; k < 3; k++) begin
      if (k == ax) begin
        p = plane;
      end else begin
        m = mag(d[k]);
        if (m == 0) begin
          p = o[k];
        end else begin
          if (t > (64'd1 << 62) / m) return 1'b0;
          term = (t * m) >> FB;
          p = (d[k] < 0) ? o[k] - longint'(term) : o[k] + longint'(term);
        end
      end
      if (p < lo || p > hi) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ray_out_t entry_face(ray_in_t r);
    longint o[3], d[3];
    longint plane, num;
    longint unsigned t, best;
    ray_out_t res;
    res = '0;
    best = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(axis_origin(r, i));
      d[i] = longint'(axis_dir(r, i));
    end
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) continue;
      if (d[i] > 0) begin
        plane = 0;
        num = -o[i];
      end else begin
        plane = ONE;
        num = o[i] - ONE;
      end
      if (num <= 0) continue;
      t = (longint'(num) << FB) / mag(d[i]);
      if (t == 0) continue;
      if (res.hit && !(t < best)) continue;
      if (point_in_margin(i, plane, o, d, t)) begin
        res.hit = 1'b1;
        best = t;
        res.face = 3'(2 * i + (d[i] < 0 ? 1 : 0));
      end
    end
    if (res.hit) res.ray_param = (best > 64'hFFFF_FFFF) ? '1 : best[31:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 6 * ONE)) - 3 * ONE);
      2: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE / 2);
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(ONE * $urandom_range(0, 1));
    endcase
  endfunction

  // Aims most random rays at a point near the cube so hits are common.
  function automatic ray_in_t aimed_ray();
    ray_in_t r;
    longint tgt[3], org[3];
    int sc;
    sc = $urandom_range(1, 4);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = longint'($urandom_range(0, ONE + 2000)) - 1000;
      org[i] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    end
    r.origin_x = 32'(org[0]); r.origin_y = 32'(org[1]); r.origin_z = 32'(org[2]);
    r.dir_x = 32'((tgt[0] - org[0]) / sc);
    r.dir_y = 32'((tgt[1] - org[1]) / sc);
    r.dir_z = 32'((tgt[2] - org[2]) / sc);
    if ($urandom_range(0, 5) == 0) r.dir_y = 0;
    return r;
  endfunction

  function automatic ray_in_t mk(longint ox, longint oy, longint oz,
                                 longint dx, longint dy, longint dz);
    ray_in_t r;
    r.origin_x = 32'(ox); r.origin_y = 32'(oy); r.origin_z = 32'(oz);
    r.dir_x = 32'(dx); r.dir_y = 32'(dy); r.dir_z = 32'(dz);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rays.size() != 0 || expected_hits.size() != 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_margin(logic [MARGIN_W-1:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    margin = v;
  endtask

  task automatic random_rays(int n);
    ray_in_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        r = aimed_ray();
      end else begin
        r = mk(longint'($signed(rand_coord())), longint'($signed(rand_coord())),
               longint'($signed(rand_coord())), longint'($signed(rand_coord())),
               longint'($signed(rand_coord())), longint'($signed(rand_coord())));
      end
      pending_rays.push_back(r);
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_hits.push_back(entry_face(in_data));
      rays_sent <= rays_sent + 1;
    end
    if (!(in_valid && in_stall)) begin
      if (drive_on && pending_rays.size() != 0 && gap_left == 0) begin
        in_valid <= 1'b1;
        in_data <= pending_rays.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  // Result side: its own stall pattern, with one long hold-off on request
  // whose length this process counts itself.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_count = hold_count + 1;
      if (hold_count >= HOLD_LEN) hold_done = 1'b1;
    end else begin
      case ((rays_sent / 128) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    ray_out_t want;
    if (!rst && out_valid && !out_stall) begin
      idle_cycles <= 0;
      results_seen <= results_seen + 1;
      if (expected_hits.size() == 0) begin
        $error("result transfer with no ray outstanding");
        errors = errors + 1;
      end else begin
        want = expected_hits.pop_front();
        hits_seen <= hits_seen + want.hit;
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
          errors = errors + 1;
        end
        if (out_data.face !== want.face) begin
          $error("face: expected %0d, got %0d", want.face, out_data.face);
          errors = errors + 1;
        end
        if (out_data.ray_param !== want.ray_param) begin
          $error("ray_param: expected %h, got %h", want.ray_param, out_data.ray_param);
          errors = errors + 1;
        end
      end
    end else if (in_valid && !in_stall) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_MAX);
        $display("** ray_unit_cube_entry_test: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays at the reset margin.
    pending_rays.push_back(mk(-ONE, ONE / 2, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(2 * ONE, ONE / 2, ONE / 2, -ONE, 0, 0));
    pending_rays.push_back(mk(ONE / 2, -ONE, ONE / 2, 0, ONE, 0));
    pending_rays.push_back(mk(ONE / 2, 2 * ONE, ONE / 2, 0, -ONE, 0));
    pending_rays.push_back(mk(ONE / 2, ONE / 2, -ONE, 0, 0, ONE));
    pending_rays.push_back(mk(ONE / 2, ONE / 2, 2 * ONE, 0, 0, -ONE));
    pending_rays.push_back(mk(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0));
    pending_rays.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    pending_rays.push_back(mk(-ONE, -ONE, ONE / 2, ONE, ONE, 0));
    pending_rays.push_back(mk(-ONE, 2 * ONE, ONE / 2, ONE, -ONE, 0));
    pending_rays.push_back(mk(-ONE, ONE + 300, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(-ONE, ONE + 400, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(-ONE, -328, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(-ONE, -329, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(32'sh8000_0000, ONE / 2, ONE / 2, 1, 0, 0));
    pending_rays.push_back(mk(32'sh7FFF_FFFF, ONE / 2, ONE / 2, -1, 0, 0));
    pending_rays.push_back(mk(-1, ONE / 2, ONE / 2, 32'sh7FFF_FFFF, 0, 0));
    pending_rays.push_back(mk(0, ONE / 2, ONE / 2, ONE, 0, 0));
    pending_rays.push_back(mk(-ONE, ONE / 2, ONE / 2, -ONE, 0, 0));
    pending_rays.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    pending_rays.push_back(mk(-1, -1, -1, -1, -1, -1));
    pending_rays.push_back(mk(-ONE, -ONE, ONE / 2, ONE, 2 * ONE, 0));
    drive_on = 1'b1;
    wait_drained();

    // Long hold-off on the result side while rays keep coming.
    random_rays(150);
    hold_req = 1'b1;
    wait (hold_done);
    wait_drained();
    random_rays(150);
    wait_drained();

    write_margin(16'd0);
    random_rays(200);
    wait_drained();
    write_margin(16'hFFFF);
    random_rays(200);
    wait_drained();
    write_margin(16'(ONE / 8));
    random_rays(150);
    wait_drained();
    write_margin(EDGE_MARGIN_RST);
    random_rays(150);
    wait_drained();

    $display("Run covered %0d rays, %0d results, %0d hits, over four edge margins.",
             rays_sent, results_seen, hits_seen);
    if (errors == 0) begin
      $display("** ray_unit_cube_entry_test: PASSED **");
    end else begin
      $display("** ray_unit_cube_entry_test: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
src/rucet_pkg.sv
src/rucet_prep.sv
src/rucet_div.sv
src/rucet_check.sv
src/ray_unit_cube_entry_test.sv
sim/ray_unit_cube_entry_test_tb.sv
